[hw/rtl/fsmrs_pkg.sv]
// ----------------------------------------------------------------------------
// fsmrs_pkg
// Shared constants, command codes and controller/datapath interface types
// for the state table with reachability mark and sweep.
// ----------------------------------------------------------------------------
package fsmrs_pkg;

  localparam int IDX_W      = 3;
  localparam int NUM_STATES = 1 << IDX_W;
  localparam int CNT_W      = IDX_W + 1;
  localparam int KIND_W     = 3;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 24;

  localparam logic [KIND_W-1:0] KIND_STEP   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CHANGE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_REPORT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

  localparam logic [IDX_W-1:0] RESET_STATE = 3'd4;

  // example machine, A..H = 0..7
  localparam logic [IDX_W-1:0] INIT_ZERO [NUM_STATES] = '{
    3'd7, 3'd2, 3'd6, 3'd5, 3'd0, 3'd1, 3'd4, 3'd3
  };
  localparam logic [IDX_W-1:0] INIT_ONE [NUM_STATES] = '{
    3'd2, 3'd5, 3'd7, 3'd0, 3'd3, 3'd6, 3'd6, 3'd1
  };

  typedef struct packed {
    logic load_in;
    logic exec;
    logic walk_start;
    logic walk_pop;
    logic sweep;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic              queue_empty;
    logic [KIND_W-1:0] kind;
  } dp_status_t;

endpackage

[hw/rtl/fsmrs_ctrl.sv]
// ----------------------------------------------------------------------------
// fsmrs_ctrl
// Sequencer: takes a command transfer, runs the breadth-first walk and sweep
// when needed, and hands the result to the output register.
// ----------------------------------------------------------------------------
module fsmrs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  fsmrs_pkg::dp_status_t status,
  output fsmrs_pkg::dp_cmd_t    cmd
);
  import fsmrs_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_WALK   = 3'd2;
  localparam logic [2:0] S_SWEEP  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state, state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.kind == KIND_REPORT || status.kind == KIND_DELETE) begin
          cmd.walk_start = 1'b1;
          state_next     = S_WALK;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_WALK: begin
        if (status.queue_empty) begin
          state_next = S_SWEEP;
        end else begin
          cmd.walk_pop = 1'b1;
        end
      end
      S_SWEEP: begin
        cmd.sweep  = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/fsmrs_datapath.sv]
// ----------------------------------------------------------------------------
// fsmrs_datapath
// Transition table, deleted and visited marks, walk queue with head/tail
// pointers, present state, and the result/output registers.
// ----------------------------------------------------------------------------
module fsmrs_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  fsmrs_pkg::dp_cmd_t              cmd,
  output fsmrs_pkg::dp_status_t           status,
  input  logic [fsmrs_pkg::KIND_W-1:0]    in_kind,
  input  logic                            in_symbol_bit,
  input  logic [fsmrs_pkg::IDX_W-1:0]     in_target_state,
  input  logic [fsmrs_pkg::IDX_W-1:0]     in_entry_index,
  output logic [fsmrs_pkg::IDX_W-1:0]     current_state,
  output logic [fsmrs_pkg::NUM_STATES-1:0] unreachable_mask,
  output logic [fsmrs_pkg::IDX_W-1:0]     next_zero,
  output logic [fsmrs_pkg::IDX_W-1:0]     next_one,
  output logic                            entry_deleted
);
  import fsmrs_pkg::*;

  logic [KIND_W-1:0]     kind;
  logic                  symbol_bit;
  logic [IDX_W-1:0]      target_state;
  logic [IDX_W-1:0]      entry_index;
  logic [IDX_W-1:0]      present;
  logic [IDX_W-1:0]      tab_zero [NUM_STATES];
  logic [IDX_W-1:0]      tab_one  [NUM_STATES];
  logic [NUM_STATES-1:0] deleted;
  logic [NUM_STATES-1:0] visited;
  logic [IDX_W-1:0]      walk_queue [NUM_STATES];
  logic [CNT_W-1:0]      head;
  logic [CNT_W-1:0]      tail;
  logic [NUM_STATES-1:0] res_mask;
  logic [IDX_W-1:0]      res_zero;
  logic [IDX_W-1:0]      res_one;
  logic                  res_del;

  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W-1:0]      rd_zero;
  logic [IDX_W-1:0]      rd_one;
  logic                  en0;
  logic                  en1;
  logic [NUM_STATES-1:0] visited0;
  logic [CNT_W-1:0]      tail1;
  logic [NUM_STATES-1:0] garbage;

  assign status.queue_empty = (head == tail);
  assign status.kind        = kind;

  always_comb begin
    if (cmd.walk_pop) begin
      rd_addr = walk_queue[head[IDX_W-1:0]];
    end else if (kind == KIND_READ) begin
      rd_addr = entry_index;
    end else begin
      rd_addr = present;
    end
  end

  assign rd_zero = tab_zero[rd_addr];
  assign rd_one  = tab_one[rd_addr];

  // both successors of the popped state in the same cycle; the second sees the first's mark
  always_comb begin
    en0      = !deleted[rd_zero] && !visited[rd_zero] && (tail < CNT_W'(NUM_STATES));
    visited0 = visited;
    if (en0) begin
      visited0[rd_zero] = 1'b1;
    end
    tail1 = tail + CNT_W'(en0);
    en1   = !deleted[rd_one] && !visited0[rd_one] && (tail1 < CNT_W'(NUM_STATES));
  end

  assign garbage = ~visited & ~deleted;

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= RESET_STATE;
      deleted <= '0;
      visited <= '0;
      head    <= '0;
      tail    <= '0;
      for (int i = 0; i < NUM_STATES; i++) begin
        tab_zero[i] <= INIT_ZERO[i];
        tab_one[i]  <= INIT_ONE[i];
      end
    end else begin
      if (cmd.exec) begin
        case (kind)
          KIND_STEP: begin
            present <= symbol_bit ? rd_one : rd_zero;
          end
          KIND_CHANGE: begin
            if (symbol_bit) begin
              tab_one[present] <= target_state;
            end else begin
              tab_zero[present] <= target_state;
            end
          end
          default: begin
          end
        endcase
      end
      if (cmd.walk_start) begin
        visited <= NUM_STATES'(1) << present;
        head <= '0;
        tail <= CNT_W'(1);
      end
      if (cmd.walk_pop) begin
        head <= head + CNT_W'(1);
        tail <= tail1 + CNT_W'(en1);
        if (en1) begin
          visited <= visited0 | (NUM_STATES'(1) << rd_one);
        end else begin
          visited <= visited0;
        end
      end
      if (cmd.sweep && kind == KIND_DELETE) begin
        deleted <= deleted | garbage;
      end
    end
  end

  // payload, walk queue, result and output registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind         <= in_kind;
      symbol_bit   <= in_symbol_bit;
      target_state <= in_target_state;
      entry_index  <= in_entry_index;
      res_mask     <= '0;
      res_zero     <= '0;
      res_one      <= '0;
      res_del      <= 1'b0;
    end
    if (cmd.exec && kind == KIND_READ) begin
      res_zero <= rd_zero;
      res_one  <= rd_one;
      res_del  <= deleted[entry_index];
    end
    if (cmd.walk_start) begin
      walk_queue[0] <= present;
    end
    if (cmd.walk_pop) begin
      if (en0) begin
        walk_queue[tail[IDX_W-1:0]] <= rd_zero;
      end
      if (en1) begin
        walk_queue[tail1[IDX_W-1:0]] <= rd_one;
      end
    end
    if (cmd.sweep) begin
      res_mask <= garbage;
    end
    if (cmd.load_out) begin
      current_state    <= present;
      unreachable_mask <= res_mask;
      next_zero        <= res_zero;
      next_one         <= res_one;
      entry_deleted    <= res_del;
    end
  end

endmodule

[hw/rtl/fsm_table_with_reachability_sweep_top.sv]
// ----------------------------------------------------------------------------
// fsm_table_with_reachability_sweep_top
// State transition table with breadth-first reachability mark and sweep.
//
// Usage:
//   Commands enter on the s_axis channel (kind in tuser, operands in tdata).
//   Every command produces exactly one result transfer on m_axis.
//   Step, change, read and unknown kinds go from the execute state to the
//   finish state, which raises m_axis_tvalid once the output register is free.
//   Report and delete run a walk over the table, one queued state (both
//   successors) per cycle until the queue is empty, then a one-cycle sweep.
//   The walk reaches 1..8 states. One command is in flight at a time; s_axis_tready
//   is high only while the sequencer is idle, so a new command waits for the last.
//   A finished result waits in the output register, so a
//   new command is taken while m_axis is stalled; the next result then holds
//   in the sequencer until the output register frees up.
//   Reset loads the example machine into the table, clears all deleted
//   marks, sets the present state to E (4) and drops m_axis_tvalid.
// ----------------------------------------------------------------------------
module fsm_table_with_reachability_sweep_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] symbol_bit, [3:1] target_state, [6:4] entry_index, [7] zero
  input  logic [fsmrs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [2:0] kind
  input  logic [fsmrs_pkg::KIND_W-1:0]      s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [2:0] current_state, [10:3] unreachable_mask, [13:11] next_zero,
  // [16:14] next_one, [17] entry_deleted, [23:18] zero
  output logic [fsmrs_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
  import fsmrs_pkg::*;

  dp_cmd_t               cmd;
  dp_status_t            status;
  logic [IDX_W-1:0]      current_state;
  logic [NUM_STATES-1:0] unreachable_mask;
  logic [IDX_W-1:0]      next_zero;
  logic [IDX_W-1:0]      next_one;
  logic                  entry_deleted;

  fsmrs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  fsmrs_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .in_kind          (s_axis_tuser),
    .in_symbol_bit    (s_axis_tdata[0]),
    .in_target_state  (s_axis_tdata[3:1]),
    .in_entry_index   (s_axis_tdata[6:4]),
    .current_state    (current_state),
    .unreachable_mask (unreachable_mask),
    .next_zero        (next_zero),
    .next_one         (next_one),
    .entry_deleted    (entry_deleted)
  );

  assign m_axis_tdata = {6'd0, entry_deleted, next_one, next_zero, unreachable_mask,
                         current_state};

endmodule

[verif/tb_fsm_table_with_reachability_sweep_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_fsm_table_with_reachability_sweep_top
// Self-checking bench for the state table with reachability mark and sweep.
// A short table of directed commands runs first: reads of the reset machine,
// unknown kinds, an isolated present state, deletion of one unreachable
// state, and stepping into and walking from a deleted state. Random commands
// follow. Every command is run through a local model of the table and each
// result transfer is compared field by field against the oldest prediction.
// Both stream sides stall at random, with stretches of full throughput.
// ----------------------------------------------------------------------------
module tb_fsm_table_with_reachability_sweep_top;
  import fsmrs_pkg::*;

  localparam logic [KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_UNUSED_HI = 3'd7;
  localparam int RAND_ITEMS     = 1000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PLAN_LEN       = 24;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              sym;
    logic [IDX_W-1:0]  target;
    logic [IDX_W-1:0]  idx;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0] cur;
    logic [7:0]       mask;
    logic [IDX_W-1:0] nxt0;
    logic [IDX_W-1:0] nxt1;
    logic             deleted;
  } result_t;

  typedef struct packed {
    cmd_t    cmd;
    logic    fixed;
    result_t res;
  } plan_row_t;

  localparam result_t NO_RES = '0;

  // fixed = 1: expected result typed in; otherwise taken from the table model
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{'{KIND_READ,      1'b0, 3'd0, 3'd4}, 1'b1, '{3'd4, 8'h00, 3'd0, 3'd3, 1'b0}},
    '{'{KIND_READ,      1'b0, 3'd0, 3'd0}, 1'b1, '{3'd4, 8'h00, 3'd7, 3'd2, 1'b0}},
    '{'{KIND_READ,      1'b1, 3'd7, 3'd7}, 1'b1, '{3'd4, 8'h00, 3'd3, 3'd1, 1'b0}},
    '{'{KIND_UNUSED_LO, 1'b1, 3'd7, 3'd7}, 1'b1, '{3'd4, 8'h00, 3'd0, 3'd0, 1'b0}},
    '{'{KIND_UNUSED_HI, 1'b0, 3'd0, 3'd0}, 1'b1, '{3'd4, 8'h00, 3'd0, 3'd0, 1'b0}},
    '{'{KIND_REPORT,    1'b0, 3'd0, 3'd0}, 1'b0, NO_RES},
    '{'{KIND_CHANGE,    1'b0, 3'd4, 3'd0}, 1'b0, NO_RES},
    '{'{KIND_CHANGE,    1'b1, 3'd4, 3'd0}, 1'b0, NO_RES},
    '{'{KIND_REPORT,    1'b0, 3'd0, 3'd0}, 1'b1, '{3'd4, 8'hEF, 3'd0, 3'd0, 1'b0}},
    '{'{KIND_STEP,      1'b1, 3'd0, 3'd0}, 1'b0, NO_RES},
    '{'{KIND_CHANGE,    1'b0, 3'd0, 3'd0}, 1'b0, NO_RES},
    '{'{KIND_STEP,      1'b0, 3'd0, 3'd0}, 1'b0, NO_RES},
    '{'{KIND_STEP,      1'b0, 3'd0, 3'd0}, 1'b0, NO_RES},
    '{'{KIND_CHANGE,    1'b1, 3'd3, 3'd0}, 1'b0, NO_RES},
    '{'{KIND_STEP,      1'b0, 3'd0, 3'd0}, 1'b0, NO_RES},
    '{'{KIND_STEP,      1'b0, 3'd0, 3'd0}, 1'b0, NO_RES},
    '{'{KIND_CHANGE,    1'b0, 3'd6, 3'd0}, 1'b0, NO_RES},
    '{'{KIND_REPORT,    1'b0, 3'd0, 3'd0}, 1'b0, NO_RES},
    '{'{KIND_DELETE,    1'b0, 3'd0, 3'd0}, 1'b0, NO_RES},
    '{'{KIND_READ,      1'b0, 3'd0, 3'd1}, 1'b0, NO_RES},
    '{'{KIND_CHANGE,    1'b1, 3'd1, 3'd0}, 1'b0, NO_RES},
    '{'{KIND_STEP,      1'b1, 3'd0, 3'd0}, 1'b0, NO_RES},
    '{'{KIND_REPORT,    1'b0, 3'd0, 3'd0}, 1'b0, NO_RES},
    '{'{KIND_STEP,      1'b0, 3'd0, 3'd0}, 1'b0, NO_RES}
  };

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [KIND_W-1:0]     s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // table model
  logic [IDX_W-1:0] tbl_zero [NUM_STATES];
  logic [IDX_W-1:0] tbl_one  [NUM_STATES];
  logic [NUM_STATES-1:0] gone;
  logic [IDX_W-1:0] cur_state;

  result_t expected_results [$];
  int      err_cnt;
  logic    quiet_phase;

  fsm_table_with_reachability_sweep_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // breadth-first walk from the present state, deleted states skipped
  function automatic logic [7:0] garbage_mask();
    logic [NUM_STATES-1:0] seen;
    logic [IDX_W-1:0]      fifo [NUM_STATES];
    logic [IDX_W-1:0]      s;
    logic [IDX_W-1:0]      nx;
    int                    head;
    int                    tail;
    seen = '0;
    seen[cur_state] = 1'b1;
    fifo[0] = cur_state;
    head = 0;
    tail = 1;
    while (head < tail) begin
      s = fifo[head];
      head++;
      for (int b = 0; b < 2; b++) begin
        nx = (b == 1) ? tbl_one[s] : tbl_zero[s];
        if (!gone[nx] && !seen[nx]) begin
          seen[nx] = 1'b1;
          fifo[tail] = nx;
          tail++;
        end
      end
    end
    return ~seen & ~gone;
  endfunction

  function automatic result_t run_command(input cmd_t c);
    result_t r;
    r = '0;
    case (c.kind)
      KIND_STEP:   cur_state = c.sym ? tbl_one[cur_state] : tbl_zero[cur_state];
      KIND_CHANGE: begin
        if (c.sym) tbl_one[cur_state] = c.target;
        else tbl_zero[cur_state] = c.target;
      end
      KIND_REPORT: r.mask = garbage_mask();
      KIND_DELETE: begin
        r.mask = garbage_mask();
        gone = gone | r.mask;
      end
      KIND_READ: begin
        r.nxt0    = tbl_zero[c.idx];
        r.nxt1    = tbl_one[c.idx];
        r.deleted = gone[c.idx];
      end
      default: ;
    endcase
    r.cur = cur_state;
    return r;
  endfunction

  task automatic send_command(input cmd_t c, input int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, c.idx, c.target, c.sym};
    s_axis_tuser  <= c.kind;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  function automatic int draw_gap();
    return quiet_phase ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic cmd_t random_command();
    cmd_t c;
    int   pick;
    c.sym    = 1'($urandom_range(0, 1));
    c.target = IDX_W'($urandom_range(0, NUM_STATES - 1));
    c.idx    = IDX_W'($urandom_range(0, NUM_STATES - 1));
    pick     = $urandom_range(0, 99);
    if (pick < 35) c.kind = KIND_STEP;
    else if (pick < 60) c.kind = KIND_CHANGE;
    else if (pick < 75) c.kind = KIND_REPORT;
    else if (pick < 90) c.kind = KIND_READ;
    else if (pick < 92) c.kind = KIND_DELETE;
    else c.kind = KIND_W'(KIND_UNUSED_LO +
                          $urandom_range(0, KIND_UNUSED_HI - KIND_UNUSED_LO));
    return c;
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.cur     = m_axis_tdata[2:0];
      got.mask    = m_axis_tdata[10:3];
      got.nxt0    = m_axis_tdata[13:11];
      got.nxt1    = m_axis_tdata[16:14];
      got.deleted = m_axis_tdata[17];
      if (expected_results.size() == 0) begin
        $error("result transfer with no prediction waiting: %h", m_axis_tdata);
        err_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (got.cur !== want.cur) begin
          $error("current_state: expected %0d, got %0d", want.cur, got.cur);
          err_cnt++;
        end
        if (got.mask !== want.mask) begin
          $error("unreachable_mask: expected %h, got %h", want.mask, got.mask);
          err_cnt++;
        end
        if (got.nxt0 !== want.nxt0) begin
          $error("next_zero: expected %0d, got %0d", want.nxt0, got.nxt0);
          err_cnt++;
        end
        if (got.nxt1 !== want.nxt1) begin
          $error("next_one: expected %0d, got %0d", want.nxt1, got.nxt1);
          err_cnt++;
        end
        if (got.deleted !== want.deleted) begin
          $error("entry_deleted: expected %0d, got %0d", want.deleted, got.deleted);
          err_cnt++;
        end
      end
    end
  end

  // result sink with random stalls
  initial begin
    int hold;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      hold = draw_gap();
      if (hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid === 1'b1 && !rst));
    end
  end

  // watchdog on cycles without any transfer
  initial begin
    int idle_cnt;
    idle_cnt = 0;
    while (idle_cnt < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cnt = 0;
      else idle_cnt++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    cmd_t    c;
    result_t r;
    err_cnt     = 0;
    quiet_phase = 1'b0;
    for (int i = 0; i < NUM_STATES; i++) begin
      tbl_zero[i] = INIT_ZERO[i];
      tbl_one[i]  = INIT_ONE[i];
    end
    gone      = '0;
    cur_state = RESET_STATE;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_LEN; i++) begin
      send_command(PLAN[i].cmd, draw_gap());
      r = run_command(PLAN[i].cmd);
      expected_results.push_back(PLAN[i].fixed ? PLAN[i].res : r);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) quiet_phase = ($urandom_range(0, 2) == 0);
      if (n == RAND_ITEMS / 2) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (expected_results.size() != 0);
      end
      c = random_command();
      send_command(c, draw_gap());
      expected_results.push_back(run_command(c));
    end
    s_axis_tvalid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d predicted results never arrived", expected_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
